>>> design/iba_pkg.sv
// ----------------------------------------------------------------------------
// iba_pkg: shared types and constants of the identifier bitmap allocator
// Operation and status codes, and the default identifier count.
// ----------------------------------------------------------------------------
package iba_pkg;

   localparam int IdCountDefault = 1024;
   localparam int WordBits       = 64;
   localparam int BitIdxW        = 6;
   localparam int FreeIdW        = 16;
   localparam int GivenIdW       = 10;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NONE_FREE = 2'd1,
      ST_RANGE     = 2'd2
   } status_type;

endpackage

>>> design/iba_req_if.sv
// ----------------------------------------------------------------------------
// iba_req_if: request channel of the identifier bitmap allocator
// Valid/ready handshake carrying the operation and the identifier to free.
// ----------------------------------------------------------------------------
interface iba_req_if;
   logic                           valid;
   logic                           ready;
   iba_pkg::func_type              func;
   logic [iba_pkg::FreeIdW-1:0]    free_id;

   modport source (output valid, output func, output free_id, input ready);
   modport sink   (input valid, input func, input free_id, output ready);
endinterface

>>> design/iba_rsp_if.sv
// ----------------------------------------------------------------------------
// iba_rsp_if: response channel of the identifier bitmap allocator
// Valid/ready handshake carrying the granted identifier and the status.
// ----------------------------------------------------------------------------
interface iba_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [iba_pkg::GivenIdW-1:0]   given_id;
   iba_pkg::status_type            status;

   modport source (output valid, output given_id, output status, input ready);
   modport sink   (input valid, input given_id, input status, output ready);
endinterface

>>> design/iba_mark_ram.sv
// ----------------------------------------------------------------------------
// iba_mark_ram: free-mark word memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iba_mark_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 64
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read one word, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/id_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// id_bitmap_allocator: lowest-free identifier allocator over a mark bitmap
// Hands out and takes back identifiers, one free mark per identifier.
// ----------------------------------------------------------------------------
// One request is worked on at a time. An allocate request scans the mark
// words one per cycle through the single read port of the mark memory and a
// 64-bit find-first-set; the granted mark is written back in the cycle it
// is found. A free request reads the word, then modifies and writes it.
// A free request out of range has its response loaded into the output
// register in the cycle it is taken. After reset a clearing pass marks
// every identifier free; no request is taken during it, configuration
// writes are. The response is held in an output register, and a new
// request is taken once that register is empty or being drained.
// ----------------------------------------------------------------------------
module id_bitmap_allocator #(
   parameter int ID_COUNT = iba_pkg::IdCountDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   iba_req_if.sink    req_ch,
   iba_rsp_if.source  rsp_ch
);
   import iba_pkg::*;

   localparam int WORD_COUNT = (ID_COUNT + WordBits - 1) / WordBits;
   localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int LAST_REM   = ID_COUNT % WordBits;
   localparam logic [WordBits-1:0] LAST_MASK =
      (LAST_REM == 0) ? {WordBits{1'b1}} : ((64'd1 << LAST_REM) - 64'd1);
   localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_FREE_RD,
      S_FREE_WR
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [AW-1:0]            chk_ff, chk_in;
   logic                     pend_ff, pend_in;
   logic [BitIdxW-1:0]       bit_ff, bit_in;
   logic                     rzero_ff, rzero_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [GivenIdW-1:0]      rsp_id_ff, rsp_id_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic [WordBits-1:0]      ram_wdata;
   logic [AW-1:0]            ram_raddr;
   logic [WordBits-1:0]      ram_rdata;

   logic                     req_take;
   logic                     out_free;
   logic                     in_range;
   logic [WordBits-1:0]      avail;
   logic                     ffs_hit;
   logic [BitIdxW-1:0]       ffs_bit;
   logic [AW+BitIdxW-1:0]    id_found;
   logic [31:0]              id_wide;

   iba_mark_ram #(
      .DEPTH (WORD_COUNT),
      .AW    (AW),
      .DW    (WordBits)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // handshake
   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE) && out_free;
   assign req_take      = req_ch.valid && req_ch.ready;
   assign in_range      = {1'b0, req_ch.free_id} < 17'(ID_COUNT);

   // mask out identifier zero when it is reserved
   always_comb begin
      avail = ram_rdata;
      if (chk_ff == '0 && rzero_ff) begin
         avail[0] = 1'b0;
      end
   end

   // find the lowest set mark
   always_comb begin
      ffs_bit = '0;
      for (int i = WordBits - 1; i >= 0; i--) begin
         if (avail[i]) begin
            ffs_bit = BitIdxW'(i);
         end
      end
      ffs_hit = |avail;
   end

   assign id_found = {chk_ff, ffs_bit};
   assign id_wide  = 32'(id_found);

   // sequencer and memory port control
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      chk_in        = chk_ff;
      pend_in       = pend_ff;
      bit_in        = bit_ff;
      rzero_in      = csr_we ? csr_wdata : rzero_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = '0;
      ram_raddr     = addr_ff;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = (addr_ff == LAST_WORD) ? LAST_MASK : {WordBits{1'b1}};
            addr_in   = addr_ff + AW'(1);
            if (addr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               if (req_ch.func == FUNC_ALLOC) begin
                  addr_in  = '0;
                  pend_in  = 1'b0;
                  state_in = S_ALLOC;
               end else if (in_range) begin
                  addr_in  = req_ch.free_id[AW+BitIdxW-1:BitIdxW];
                  bit_in   = req_ch.free_id[BitIdxW-1:0];
                  state_in = S_FREE_RD;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = '0;
                  rsp_status_in = ST_RANGE;
               end
            end
         end
         S_ALLOC: begin
            // issue the next word read while checking the previous one
            addr_in = addr_ff + AW'(1);
            chk_in  = addr_ff;
            pend_in = 1'b1;
            if (pend_ff) begin
               if (ffs_hit) begin
                  ram_we        = 1'b1;
                  ram_waddr     = chk_ff;
                  ram_wdata     = ram_rdata & ~(64'd1 << ffs_bit);
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = id_wide[GivenIdW-1:0];
                  rsp_status_in = ST_DONE;
                  state_in      = S_IDLE;
               end else if (chk_ff == LAST_WORD) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = '0;
                  rsp_status_in = ST_NONE_FREE;
                  state_in      = S_IDLE;
               end
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            ram_we        = 1'b1;
            ram_wdata     = ram_rdata | (64'd1 << bit_ff);
            rsp_valid_in  = 1'b1;
            rsp_id_in     = '0;
            rsp_status_in = ST_DONE;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         rzero_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         rzero_ff     <= rzero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_ff        <= chk_in;
      bit_ff        <= bit_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.given_id = rsp_id_ff;
   assign rsp_ch.status   = rsp_status_ff;

endmodule
